[hw/rtl/lgti_pkg.sv]
// types, constants and helpers shared by the grid interpolator files
`default_nettype none
package lgti_pkg;

    localparam int GRID_X      = 16;
    localparam int GRID_Y      = 16;
    localparam int GRID_Z      = 16;
    localparam int MAX_OUTPUTS = 8;
    localparam int FRAC_BITS   = 16;

    localparam int NPTS  = GRID_X * GRID_Y * GRID_Z;
    localparam int PW    = $clog2(NPTS);
    localparam int GW    = $clog2(NPTS * MAX_OUTPUTS);
    localparam int NACT_LIM = (MAX_OUTPUTS < 8) ? MAX_OUTPUTS : 8;
    localparam int MW    = NACT_LIM;

    localparam logic [1:0] FN_QUERY  = 2'd0;
    localparam logic [1:0] FN_WRITE  = 2'd1;
    localparam logic [1:0] FN_EVAL   = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DOMAIN  = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_WRITTEN = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    localparam logic [2:0] REG_X_ORG = 3'd0;
    localparam logic [2:0] REG_Y_ORG = 3'd1;
    localparam logic [2:0] REG_Z_ORG = 3'd2;
    localparam logic [2:0] REG_X_INV = 3'd3;
    localparam logic [2:0] REG_Y_INV = 3'd4;
    localparam logic [2:0] REG_Z_INV = 3'd5;
    localparam logic [2:0] REG_ACT   = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRD, S_WCHK, S_MAP, S_CHK,
        S_EMIT1, S_QEMIT, S_GRD, S_LERP, S_EEMIT
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [3:0]         point_x;
        logic [3:0]         point_y;
        logic [3:0]         point_z;
        logic [2:0]         comp_index;
        logic signed [31:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         corner_x;
        logic [3:0]         corner_y;
        logic [3:0]         corner_z;
        logic [2:0]         component;
        logic signed [31:0] value;
        logic               last;
    } out_item_t;

    function automatic logic [PW-1:0] pidx(input logic [3:0] x, input logic [3:0] y,
                                           input logic [3:0] z);
        pidx = PW'(32'(x) * (GRID_Y * GRID_Z) + 32'(y) * GRID_Z + 32'(z));
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lgti_if.sv]
// valid/ready stream interfaces for input items and result items
`default_nettype none
interface lgti_in_if;
    logic                valid;
    logic                ready;
    lgti_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lgti_out_if;
    logic                valid;
    logic                ready;
    lgti_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/lazy_grid_trilinear_interpolator_unit.sv]
// trilinear interpolator over a lazily filled grid held in two memories
// write: a status read, then the decision and store; query: axis mapping and
// corner status checks, then one result per missing corner; evaluate: the same
// mapping and checks, then per component 8 grid reads and 7 lerp steps; one item
// at a time, with a shared axis multiplier, one read port per memory and one lerp
// multiplier; after reset a clearing pass zeroes all 4096 point status entries
`default_nettype none
module lazy_grid_trilinear_interpolator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    lgti_in_if.sink          item_in,
    lgti_out_if.source       result_out
);

    localparam int F = lgti_pkg::FRAC_BITS;
    localparam int SW = lgti_pkg::MW + 1;

    // configuration
    logic signed [31:0] x_org_reg, y_org_reg, z_org_reg;
    logic [31:0]        x_inv_reg, y_inv_reg, z_inv_reg;
    logic [3:0]         act_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_org_reg <= '0;
            y_org_reg <= '0;
            z_org_reg <= '0;
            x_inv_reg <= 32'd65536;
            y_inv_reg <= 32'd65536;
            z_inv_reg <= 32'd65536;
            act_reg   <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                lgti_pkg::REG_X_ORG: x_org_reg <= pwdata;
                lgti_pkg::REG_Y_ORG: y_org_reg <= pwdata;
                lgti_pkg::REG_Z_ORG: z_org_reg <= pwdata;
                lgti_pkg::REG_X_INV: x_inv_reg <= pwdata;
                lgti_pkg::REG_Y_INV: y_inv_reg <= pwdata;
                lgti_pkg::REG_Z_INV: z_inv_reg <= pwdata;
                lgti_pkg::REG_ACT:   act_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            lgti_pkg::REG_X_ORG: prdata = x_org_reg;
            lgti_pkg::REG_Y_ORG: prdata = y_org_reg;
            lgti_pkg::REG_Z_ORG: prdata = z_org_reg;
            lgti_pkg::REG_X_INV: prdata = x_inv_reg;
            lgti_pkg::REG_Y_INV: prdata = y_inv_reg;
            lgti_pkg::REG_Z_INV: prdata = z_inv_reg;
            lgti_pkg::REG_ACT:   prdata = {28'd0, act_reg};
            default:             prdata = '0;
        endcase
    end

    // effective component count and the mask of components it needs
    logic [3:0]                 nact;
    logic [lgti_pkg::MW-1:0]    need;
    always_comb
    begin
        if (act_reg == 4'd0)
            nact = 4'd1;
        else if (32'(act_reg) > lgti_pkg::NACT_LIM)
            nact = 4'(lgti_pkg::NACT_LIM);
        else
            nact = act_reg;
        need = ~({lgti_pkg::MW{1'b1}} << nact);
    end

    // memories: point status {valid, written mask} and grid values
    logic [SW-1:0] stat_mem [lgti_pkg::NPTS];
    logic [31:0]   grid_mem [lgti_pkg::NPTS * lgti_pkg::MAX_OUTPUTS];
    logic [SW-1:0]              stat_rd_reg;
    logic [31:0]                grid_rd_reg;
    logic [lgti_pkg::PW-1:0]    stat_raddr, stat_waddr;
    logic [SW-1:0]              stat_wdata;
    logic                       stat_we;
    logic [lgti_pkg::GW-1:0]    grid_raddr, grid_waddr;
    logic                       grid_we;

    // control and item state
    lgti_pkg::state_t         state_reg, state_next;
    logic [lgti_pkg::PW-1:0]  clr_reg;
    logic [3:0]               cnt_reg;
    logic [2:0]               comp_reg;
    lgti_pkg::in_item_t       item_reg;
    logic                     ood_reg;
    logic [3:0]               ix_reg, iy_reg, iz_reg;
    logic [F-1:0]             fx_reg, fy_reg, fz_reg;
    logic [63:0]              prod_reg;
    logic                     neg_reg;
    logic [7:0]               miss_reg;
    logic signed [31:0]       v_reg [8];
    logic signed [31:0]       t0_reg, t1_reg, z0_reg, z1_reg, res_reg;

    logic      in_acc, slot_free, out_load;
    lgti_pkg::out_item_t out_next;
    logic      out_valid_reg;
    lgti_pkg::out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (stat_we)
            stat_mem[stat_waddr] <= stat_wdata;
        stat_rd_reg <= stat_mem[stat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= item_reg.sample;
        grid_rd_reg <= grid_mem[grid_raddr];
    end

    assign in_acc    = item_in.valid && item_in.ready;
    assign slot_free = !out_valid_reg || result_out.ready;

    // write decision
    logic              w_ood, w_valid, w_active;
    logic [lgti_pkg::MW-1:0] w_mask;
    assign w_ood    = (32'(item_reg.point_x) >= lgti_pkg::GRID_X)
                   || (32'(item_reg.point_y) >= lgti_pkg::GRID_Y)
                   || (32'(item_reg.point_z) >= lgti_pkg::GRID_Z);
    assign w_valid  = stat_rd_reg[SW-1];
    assign w_active = {1'b0, item_reg.comp_index} < nact;
    assign w_mask   = stat_rd_reg[lgti_pkg::MW-1:0]
                    | (lgti_pkg::MW'(1) << item_reg.comp_index);

    // corner selected by the counter, and the lowest missing corner
    logic [2:0] ck;
    logic [3:0] cx, cy, cz;
    logic [2:0] first;
    logic [3:0] fcx, fcy, fcz;
    logic [7:0] miss_rest;
    assign ck = cnt_reg[2:0];
    assign cx = ix_reg + 4'(ck[2]);
    assign cy = iy_reg + 4'(ck[1]);
    assign cz = iz_reg + 4'(ck[0]);
    always_comb
    begin
        first = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (miss_reg[k])
                first = 3'(k);
        end
    end
    assign fcx = ix_reg + 4'(first[2]);
    assign fcy = iy_reg + 4'(first[1]);
    assign fcz = iz_reg + 4'(first[0]);
    assign miss_rest = miss_reg & (miss_reg - 8'd1);

    // axis mapping: one subtract and one 32x32 product per cycle
    logic signed [31:0] m_coord, m_org;
    logic [31:0]        m_inv;
    logic signed [32:0] m_d;
    logic [63:0]        p_hi;
    logic [31:0]        a_grid;
    logic               a_ood;
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin m_coord = item_reg.coord_x; m_org = x_org_reg; m_inv = x_inv_reg; end
            2'd1:    begin m_coord = item_reg.coord_y; m_org = y_org_reg; m_inv = y_inv_reg; end
            default: begin m_coord = item_reg.coord_z; m_org = z_org_reg; m_inv = z_inv_reg; end
        endcase
        m_d = {m_coord[31], m_coord} - {m_org[31], m_org};
        case (cnt_reg[1:0])
            2'd1:    a_grid = 32'(lgti_pkg::GRID_X);
            2'd2:    a_grid = 32'(lgti_pkg::GRID_Y);
            default: a_grid = 32'(lgti_pkg::GRID_Z);
        endcase
        p_hi  = prod_reg >> (2 * F);
        a_ood = neg_reg || (p_hi + 64'd1 >= 64'(a_grid));
    end

    // lerp step: a*2^F + (b-a)*f + half, floor shift, saturate
    logic signed [31:0] la, lb;
    logic [F-1:0]       lf;
    logic signed [32:0] ldiff;
    logic signed [F:0]  lfs;
    logic signed [F+33:0] lsum;
    logic signed [33:0] lsh;
    logic signed [31:0] lres;
    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    begin la = v_reg[0]; lb = v_reg[4]; lf = fx_reg; end
            3'd1:    begin la = v_reg[2]; lb = v_reg[6]; lf = fx_reg; end
            3'd2:    begin la = t0_reg;   lb = t1_reg;   lf = fy_reg; end
            3'd3:    begin la = v_reg[1]; lb = v_reg[5]; lf = fx_reg; end
            3'd4:    begin la = v_reg[3]; lb = v_reg[7]; lf = fx_reg; end
            3'd5:    begin la = t0_reg;   lb = t1_reg;   lf = fy_reg; end
            default: begin la = z0_reg;   lb = z1_reg;   lf = fz_reg; end
        endcase
        ldiff = {lb[31], lb} - {la[31], la};
        lfs   = $signed({1'b0, lf});
        lsum  = $signed({{2{la[31]}}, la, {F{1'b0}}}) + ldiff * lfs
              + $signed((F+34)'(1) << (F - 1));
        lsh   = 34'(lsum >>> F);
        if (lsh > 34'sd2147483647)
            lres = 32'h7fffffff;
        else if (lsh < -34'sd2147483648)
            lres = 32'h80000000;
        else
            lres = lsh[31:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgti_pkg::S_CLEAR:
                if (clr_reg == lgti_pkg::PW'(lgti_pkg::NPTS - 1))
                    state_next = lgti_pkg::S_IDLE;
            lgti_pkg::S_IDLE:
                if (in_acc)
                begin
                    case (item_in.data.func)
                        lgti_pkg::FN_WRITE: state_next = lgti_pkg::S_WRD;
                        lgti_pkg::FN_QUERY,
                        lgti_pkg::FN_EVAL:  state_next = lgti_pkg::S_MAP;
                        default:            state_next = lgti_pkg::S_IDLE;
                    endcase
                end
            lgti_pkg::S_WRD:  state_next = lgti_pkg::S_WCHK;
            lgti_pkg::S_WCHK:
                if (slot_free)
                    state_next = lgti_pkg::S_IDLE;
            lgti_pkg::S_MAP:
                if (cnt_reg == 4'd3)
                    state_next = (ood_reg || a_ood) ? lgti_pkg::S_EMIT1 : lgti_pkg::S_CHK;
            lgti_pkg::S_CHK:
                // the last corner's status is still on the read port here
                if (cnt_reg == 4'd8)
                begin
                    if (item_reg.func == lgti_pkg::FN_QUERY)
                        state_next = lgti_pkg::S_QEMIT;
                    else if (miss_reg != 8'd0 || !stat_rd_reg[SW-1])
                        state_next = lgti_pkg::S_EMIT1;
                    else
                        state_next = lgti_pkg::S_GRD;
                end
            lgti_pkg::S_EMIT1:
                if (slot_free)
                    state_next = lgti_pkg::S_IDLE;
            lgti_pkg::S_QEMIT:
                if (slot_free && miss_rest == 8'd0)
                    state_next = lgti_pkg::S_IDLE;
            lgti_pkg::S_GRD:
                if (cnt_reg == 4'd8)
                    state_next = lgti_pkg::S_LERP;
            lgti_pkg::S_LERP:
                if (cnt_reg == 4'd6)
                    state_next = lgti_pkg::S_EEMIT;
            lgti_pkg::S_EEMIT:
                if (slot_free)
                    state_next = ({1'b0, comp_reg} + 4'd1 == nact)
                               ? lgti_pkg::S_IDLE : lgti_pkg::S_GRD;
            default: state_next = lgti_pkg::S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        item_in.ready = 1'b0;
        out_load   = 1'b0;
        out_next   = '0;
        stat_we    = 1'b0;
        stat_waddr = clr_reg;
        stat_wdata = '0;
        stat_raddr = lgti_pkg::pidx(cx, cy, cz);
        grid_we    = 1'b0;
        grid_waddr = lgti_pkg::GW'(32'(lgti_pkg::pidx(item_reg.point_x, item_reg.point_y,
                     item_reg.point_z)) * lgti_pkg::MAX_OUTPUTS + 32'(item_reg.comp_index));
        grid_raddr = lgti_pkg::GW'(32'(lgti_pkg::pidx(cx, cy, cz)) * lgti_pkg::MAX_OUTPUTS
                     + 32'(comp_reg));
        case (state_reg)
            lgti_pkg::S_CLEAR:
                stat_we = 1'b1;
            lgti_pkg::S_IDLE:
                item_in.ready = 1'b1;
            lgti_pkg::S_WRD:
                stat_raddr = lgti_pkg::pidx(item_reg.point_x, item_reg.point_y,
                                            item_reg.point_z);
            lgti_pkg::S_WCHK:
            begin
                stat_raddr = lgti_pkg::pidx(item_reg.point_x, item_reg.point_y,
                                            item_reg.point_z);
                stat_waddr = stat_raddr;
                stat_wdata = {(w_mask & need) == need, w_mask};
                out_next.last = 1'b1;
                if (w_ood)
                    out_next.status = lgti_pkg::ST_DOMAIN;
                else
                begin
                    out_next.status   = w_valid ? lgti_pkg::ST_WRITTEN : lgti_pkg::ST_OK;
                    out_next.corner_x = item_reg.point_x;
                    out_next.corner_y = item_reg.point_y;
                    out_next.corner_z = item_reg.point_z;
                end
                if (slot_free)
                begin
                    out_load = 1'b1;
                    stat_we  = !w_ood && !w_valid && w_active;
                    grid_we  = !w_ood && !w_valid && w_active;
                end
            end
            lgti_pkg::S_EMIT1:
            begin
                out_load = slot_free;
                out_next.last = 1'b1;
                if (ood_reg)
                    out_next.status = lgti_pkg::ST_DOMAIN;
                else
                begin
                    out_next.status   = lgti_pkg::ST_MISSING;
                    out_next.corner_x = fcx;
                    out_next.corner_y = fcy;
                    out_next.corner_z = fcz;
                end
            end
            lgti_pkg::S_QEMIT:
            begin
                out_load = slot_free;
                out_next.last = (miss_rest == 8'd0);
                if (miss_reg == 8'd0)
                begin
                    out_next.status   = lgti_pkg::ST_NONE;
                    out_next.corner_x = ix_reg;
                    out_next.corner_y = iy_reg;
                    out_next.corner_z = iz_reg;
                end
                else
                begin
                    out_next.status   = lgti_pkg::ST_MISSING;
                    out_next.corner_x = fcx;
                    out_next.corner_y = fcy;
                    out_next.corner_z = fcz;
                end
            end
            lgti_pkg::S_EEMIT:
            begin
                out_load = slot_free;
                out_next.status    = lgti_pkg::ST_OK;
                out_next.corner_x  = ix_reg;
                out_next.corner_y  = iy_reg;
                out_next.corner_z  = iz_reg;
                out_next.component = comp_reg;
                out_next.value     = res_reg;
                out_next.last      = ({1'b0, comp_reg} + 4'd1 == nact);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgti_pkg::S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lgti_pkg::S_CLEAR)
                clr_reg <= clr_reg + lgti_pkg::PW'(1);
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 4'd1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
        case (state_reg)
            lgti_pkg::S_IDLE:
            begin
                item_reg <= item_in.data;
                ood_reg  <= 1'b0;
                miss_reg <= '0;
                comp_reg <= '0;
            end
            lgti_pkg::S_MAP:
            begin
                prod_reg <= 64'(m_d[31:0]) * 64'(m_inv);
                neg_reg  <= m_d[32];
                if (cnt_reg != 4'd0)
                begin
                    if (a_ood)
                        ood_reg <= 1'b1;
                    case (cnt_reg[1:0])
                        2'd1:    begin ix_reg <= p_hi[3:0]; fx_reg <= prod_reg[2*F-1:F]; end
                        2'd2:    begin iy_reg <= p_hi[3:0]; fy_reg <= prod_reg[2*F-1:F]; end
                        default: begin iz_reg <= p_hi[3:0]; fz_reg <= prod_reg[2*F-1:F]; end
                    endcase
                end
            end
            lgti_pkg::S_CHK:
                if (cnt_reg != 4'd0)
                    miss_reg[3'(cnt_reg - 4'd1)] <= !stat_rd_reg[SW-1];
            lgti_pkg::S_QEMIT:
                if (slot_free)
                    miss_reg <= miss_rest;
            lgti_pkg::S_GRD:
                if (cnt_reg != 4'd0)
                    v_reg[3'(cnt_reg - 4'd1)] <= grid_rd_reg;
            lgti_pkg::S_LERP:
                case (cnt_reg[2:0])
                    3'd0, 3'd3: t0_reg  <= lres;
                    3'd1, 3'd4: t1_reg  <= lres;
                    3'd2:       z0_reg  <= lres;
                    3'd5:       z1_reg  <= lres;
                    default:    res_reg <= lres;
                endcase
            lgti_pkg::S_EEMIT:
                if (slot_free)
                    comp_reg <= comp_reg + 3'd1;
            default: ;
        endcase
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_reg;

    // no item is taken while the status memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lgti_pkg::S_CLEAR |-> !item_in.ready)
        else $error("item accepted during clearing pass");

    // an accepted item with a defined function starts work
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && item_in.data.func != lgti_pkg::FN_UNUSED |=> state_reg != lgti_pkg::S_IDLE)
        else $error("accepted item dropped");

    // a result is loaded only into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("pending result overwritten");

    // grid stores happen only while deciding a write transfer
    a_grid_we: assert property (@(posedge clk) disable iff (!rst_n)
        grid_we |-> state_reg == lgti_pkg::S_WCHK && stat_we)
        else $error("stray grid write");

endmodule
`default_nettype wire

[verif/lazy_grid_trilinear_interpolator_unit_tb.sv]
// testbench for the lazily filled trilinear interpolation grid
`default_nettype none
module lazy_grid_trilinear_interpolator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] cx, cy, cz;
        logic [3:0]  px, py, pz;
        logic [2:0]  comp;
        logic [31:0] sample;
        bit          typed;
        logic [2:0]  st;
        logic [3:0]  ex, ey, ez;
    } plan_row_t;

    bit clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    lgti_in_if  item_if ();
    lgti_out_if res_if ();

    lazy_grid_trilinear_interpolator_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_in    (item_if.sink),
        .result_out (res_if.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the grid and the registers
    logic signed [31:0] grid_mem [lgti_pkg::NPTS*lgti_pkg::MAX_OUTPUTS];
    bit                 pt_valid [lgti_pkg::NPTS];
    bit [7:0]           comp_mask [lgti_pkg::NPTS];
    logic signed [31:0] org [3];
    logic [31:0]        inv [3];
    logic [3:0]         act_reg;

    lgti_pkg::out_item_t due_results [$];
    int errors = 0;
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;

    function automatic int eff_count();
        int a;
        a = act_reg;
        if (a < 1) a = 1;
        if (a > lgti_pkg::NACT_LIM) a = lgti_pkg::NACT_LIM;
        return a;
    endfunction

    function automatic int pt_index(int x, int y, int z);
        return (x * lgti_pkg::GRID_Y + y) * lgti_pkg::GRID_Z + z;
    endfunction

    function automatic bit map_axis(input logic signed [31:0] c, input int ax,
                                    output int idx, output longint frac);
        longint d;
        logic [63:0] p;
        d = longint'(c) - longint'(org[ax]);
        idx = 0;
        frac = 0;
        if (d < 0) return 1'b0;
        p = d * {32'd0, inv[ax]};
        if (p[63:32] >= 64'(lgti_pkg::GRID_X - 1)) return 1'b0;
        idx = int'(p[63:32]);
        frac = longint'(p[31:16]);
        return 1'b1;
    endfunction

    function automatic longint lerp(longint a, longint b, longint f);
        return (a * (65536 - f) + b * f + 32768) >>> lgti_pkg::FRAC_BITS;
    endfunction

    function automatic lgti_pkg::out_item_t mk(logic [2:0] st, int x, int y, int z,
                                               int comp, longint val, bit last);
        lgti_pkg::out_item_t r;
        if (val > 64'sd2147483647) val = 64'sd2147483647;
        if (val < -64'sd2147483648) val = -64'sd2147483648;
        r.status = st;
        r.corner_x = 4'(x);
        r.corner_y = 4'(y);
        r.corner_z = 4'(z);
        r.component = 3'(comp);
        r.value = val[31:0];
        r.last = last;
        return r;
    endfunction

    // true when an evaluate would read a component never written
    function automatic bit reads_unwritten(lgti_pkg::in_item_t it);
        int ix, iy, iz, p;
        longint fx, fy, fz;
        if (!(map_axis(it.coord_x, 0, ix, fx) && map_axis(it.coord_y, 1, iy, fy) &&
              map_axis(it.coord_z, 2, iz, fz)))
            return 1'b0;
        for (int c = 0; c < 8; c++)
        begin
            if (!pt_valid[pt_index(ix + c[2], iy + c[1], iz + c[0])]) return 1'b0;
        end
        for (int c = 0; c < 8; c++)
        begin
            p = pt_index(ix + c[2], iy + c[1], iz + c[0]);
            for (int k = 0; k < eff_count(); k++)
                if (!comp_mask[p][k]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void grid_step(lgti_pkg::in_item_t it,
                                      ref lgti_pkg::out_item_t res[$]);
        int ix, iy, iz, p, n, nact;
        longint fx, fy, fz, y0, y1, z0, z1;
        longint v [8];
        bit [7:0] need;
        nact = eff_count();
        if (it.func == lgti_pkg::FN_UNUSED) return;
        if (it.func == lgti_pkg::FN_WRITE)
        begin
            p = pt_index(it.point_x, it.point_y, it.point_z);
            if (pt_valid[p])
            begin
                res.push_back(mk(lgti_pkg::ST_WRITTEN, it.point_x, it.point_y, it.point_z,
                                 0, 0, 1));
                return;
            end
            if (it.comp_index < nact)
            begin
                need = 8'((9'd1 << nact) - 1);
                grid_mem[p * lgti_pkg::MAX_OUTPUTS + it.comp_index] = it.sample;
                comp_mask[p][it.comp_index] = 1'b1;
                if ((comp_mask[p] & need) == need) pt_valid[p] = 1'b1;
            end
            res.push_back(mk(lgti_pkg::ST_OK, it.point_x, it.point_y, it.point_z, 0, 0, 1));
            return;
        end
        if (!(map_axis(it.coord_x, 0, ix, fx) && map_axis(it.coord_y, 1, iy, fy) &&
              map_axis(it.coord_z, 2, iz, fz)))
        begin
            res.push_back(mk(lgti_pkg::ST_DOMAIN, 0, 0, 0, 0, 0, 1));
            return;
        end
        n = 0;
        for (int c = 0; c < 8; c++)
        begin
            if (pt_valid[pt_index(ix + c[2], iy + c[1], iz + c[0])]) continue;
            res.push_back(mk(lgti_pkg::ST_MISSING, ix + c[2], iy + c[1], iz + c[0],
                             0, 0, 0));
            n++;
            if (it.func == lgti_pkg::FN_EVAL) break;
        end
        if (n != 0)
        begin
            res[res.size() - 1].last = 1'b1;
            return;
        end
        if (it.func == lgti_pkg::FN_QUERY)
        begin
            res.push_back(mk(lgti_pkg::ST_NONE, ix, iy, iz, 0, 0, 1));
            return;
        end
        for (int k = 0; k < nact; k++)
        begin
            for (int c = 0; c < 8; c++)
                v[c] = longint'(grid_mem[pt_index(ix + c[2], iy + c[1], iz + c[0])
                                         * lgti_pkg::MAX_OUTPUTS + k]);
            y0 = lerp(v[0], v[4], fx);
            y1 = lerp(v[2], v[6], fx);
            z0 = lerp(y0, y1, fy);
            y0 = lerp(v[1], v[5], fx);
            y1 = lerp(v[3], v[7], fx);
            z1 = lerp(y0, y1, fy);
            res.push_back(mk(lgti_pkg::ST_OK, ix, iy, iz, k, lerp(z0, z1, fz),
                             k + 1 == nact));
        end
    endfunction

    // result checking
    always @(posedge clk)
    begin
        lgti_pkg::out_item_t got, want;
        if (res_if.valid && res_if.ready)
        begin
            got = res_if.data;
            if (due_results.size() == 0)
            begin
                $error("unexpected result, status %0d", got.status);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.corner_x !== want.corner_x)
                begin
                    $error("corner_x: expected %0d, got %0d", want.corner_x, got.corner_x);
                    errors++;
                end
                if (got.corner_y !== want.corner_y)
                begin
                    $error("corner_y: expected %0d, got %0d", want.corner_y, got.corner_y);
                    errors++;
                end
                if (got.corner_z !== want.corner_z)
                begin
                    $error("corner_z: expected %0d, got %0d", want.corner_z, got.corner_z);
                    errors++;
                end
                if (got.component !== want.component)
                begin
                    $error("component: expected %0d, got %0d", want.component, got.component);
                    errors++;
                end
                if (got.value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, got.value);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // result side back-pressure, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            lgti_pkg::REG_X_ORG: org[0] = val;
            lgti_pkg::REG_Y_ORG: org[1] = val;
            lgti_pkg::REG_Z_ORG: org[2] = val;
            lgti_pkg::REG_X_INV: inv[0] = val;
            lgti_pkg::REG_Y_INV: inv[1] = val;
            lgti_pkg::REG_Z_INV: inv[2] = val;
            lgti_pkg::REG_ACT:   act_reg = val[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                            logic [3:0] act);
        wait_drained();
        reg_write(lgti_pkg::REG_X_ORG, ox);
        reg_write(lgti_pkg::REG_Y_ORG, oy);
        reg_write(lgti_pkg::REG_Z_ORG, oz);
        reg_write(lgti_pkg::REG_X_INV, ix);
        reg_write(lgti_pkg::REG_Y_INV, iy);
        reg_write(lgti_pkg::REG_Z_INV, iz);
        reg_write(lgti_pkg::REG_ACT, {28'd0, act});
    endtask

    // offer one item, wait for its transfer, then queue the results it should give
    task automatic send_item(lgti_pkg::in_item_t it, bit typed,
                             lgti_pkg::out_item_t typed_res);
        lgti_pkg::out_item_t res [$];
        if (it.func == lgti_pkg::FN_EVAL && reads_unwritten(it)) it.func = lgti_pkg::FN_QUERY;
        item_if.valid <= 1'b1;
        item_if.data <= it;
        do @(posedge clk); while (!item_if.ready);
        grid_step(it, res);
        if (typed)
        begin
            if (it.func != lgti_pkg::FN_UNUSED) due_results.push_back(typed_res);
        end
        else
            foreach (res[i]) due_results.push_back(res[i]);
        if ($urandom_range(99) < in_gap_pct)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] coord_in_cell(int ax, int idx);
        logic [63:0] target, d;
        target = (64'(idx) << 32) | (64'($urandom_range(0, 65535)) << 16);
        d = (target + 64'(inv[ax]) - 1) / 64'(inv[ax]);
        return org[ax] + d[31:0];
    endfunction

    // mostly fills the corners of one cell and probes it; the rest is noise
    task automatic run_random(int count);
        lgti_pkg::in_item_t it;
        lgti_pkg::out_item_t none;
        int cx, cy, cz, r, p;
        bit found;
        none = '0;
        cx = $urandom_range(0, 13);
        cy = $urandom_range(0, 13);
        cz = $urandom_range(0, 13);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            it = '0;
            it.sample = $urandom;
            if (r < 45)
            begin
                it.func = lgti_pkg::FN_WRITE;
                found = 1'b0;
                if ($urandom_range(99) < 80)
                    for (int c = 0; c < 8 && !found; c++)
                    begin
                        p = pt_index(cx + c[2], cy + c[1], cz + c[0]);
                        for (int k = 0; k < eff_count() && !found; k++)
                            if (!pt_valid[p] && !comp_mask[p][k])
                            begin
                                found = 1'b1;
                                it.point_x = 4'(cx + c[2]);
                                it.point_y = 4'(cy + c[1]);
                                it.point_z = 4'(cz + c[0]);
                                it.comp_index = 3'(k);
                            end
                    end
                if (!found)
                begin
                    it.point_x = 4'(cx + $urandom_range(0, 1));
                    it.point_y = 4'(cy + $urandom_range(0, 1));
                    it.point_z = 4'(cz + $urandom_range(0, 1));
                    it.comp_index = 3'($urandom_range(0, 7));
                end
            end
            else if (r < 80)
            begin
                it.func = ($urandom_range(99) < 60) ? lgti_pkg::FN_EVAL : lgti_pkg::FN_QUERY;
                it.coord_x = coord_in_cell(0, cx);
                it.coord_y = coord_in_cell(1, cy);
                it.coord_z = coord_in_cell(2, cz);
            end
            else
            begin
                it.func = 2'($urandom_range(0, 3));
                it.coord_x = $urandom;
                it.coord_y = $urandom;
                it.coord_z = $urandom;
                it.point_x = 4'($urandom);
                it.point_y = 4'($urandom);
                it.point_z = 4'($urandom);
                it.comp_index = 3'($urandom);
            end
            send_item(it, 1'b0, none);
        end
    endtask

    plan_row_t plan [0:22] = '{
        '{lgti_pkg::FN_QUERY, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_EVAL, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0, 1,
          lgti_pkg::ST_MISSING, 0, 0, 0},
        '{lgti_pkg::FN_QUERY, 32'hFFFFFFFF, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0, 1,
          lgti_pkg::ST_DOMAIN, 0, 0, 0},
        '{lgti_pkg::FN_EVAL, 32'h000F0000, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0, 1,
          lgti_pkg::ST_DOMAIN, 0, 0, 0},
        '{lgti_pkg::FN_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 15, 15, 15, 7,
          32'hFFFFFFFF, 1, lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 32'h7FFFFFFF, 1,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0, 1,
          lgti_pkg::ST_WRITTEN, 0, 0, 0},
        // component beyond the active count is dropped
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 1, 0, 0, 7, 32'h80000000, 1,
          lgti_pkg::ST_OK, 1, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 1, 0, 0, 0, 32'h80000000, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 0, 1, 0, 0, 32'h12345678, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 1, 1, 0, 0, 32'hFFFF0000, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 1, 0, 32'h00010000, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 1, 0, 1, 0, 32'h7FFFFFFF, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 0, 1, 1, 0, 32'h80000000, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_QUERY, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 0, 32'h0, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 1, 1, 1, 0, 32'hFFFFFFFF, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_QUERY, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 0, 32'h0, 1,
          lgti_pkg::ST_NONE, 0, 0, 0},
        '{lgti_pkg::FN_EVAL, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_EVAL, 32'hFFFF, 32'hFFFF, 32'hFFFF, 0, 0, 0, 0, 32'h0, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_EVAL, 32'h7FFFFFFF, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0, 1,
          lgti_pkg::ST_DOMAIN, 0, 0, 0},
        '{lgti_pkg::FN_WRITE, 32'h0, 32'h0, 32'h0, 15, 15, 15, 7, 32'h0, 1,
          lgti_pkg::ST_OK, 15, 15, 15},
        '{lgti_pkg::FN_QUERY, 32'hEFFFF, 32'hEFFFF, 32'hEFFFF, 0, 0, 0, 0, 32'h0, 0,
          lgti_pkg::ST_OK, 0, 0, 0},
        '{lgti_pkg::FN_QUERY, 32'h0, 32'h0, 32'h80000000, 0, 0, 0, 0, 32'h0, 1,
          lgti_pkg::ST_DOMAIN, 0, 0, 0}
    };

    function automatic logic [31:0] small_origin();
        return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
    endfunction

    initial
    begin
        lgti_pkg::in_item_t it;
        lgti_pkg::out_item_t want;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_if.valid = 1'b0;
        item_if.data = '0;
        org = '{32'd0, 32'd0, 32'd0};
        inv = '{32'd65536, 32'd65536, 32'd65536};
        act_reg = 4'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            it = '0;
            it.func = plan[i].func;
            it.coord_x = plan[i].cx;
            it.coord_y = plan[i].cy;
            it.coord_z = plan[i].cz;
            it.point_x = plan[i].px;
            it.point_y = plan[i].py;
            it.point_z = plan[i].pz;
            it.comp_index = plan[i].comp;
            it.sample = plan[i].sample;
            want = mk(plan[i].st, plan[i].ex, plan[i].ey, plan[i].ez, 0, 0, 1);
            send_item(it, plan[i].typed, want);
        end
        item_if.valid <= 1'b0;

        set_grid(small_origin(), small_origin(), small_origin(),
                 32'd65536, 32'd65536, 32'd65536, 4'd2);
        in_gap_pct = 55;
        run_random(20);
        item_if.valid <= 1'b0;

        // extreme register values
        set_grid(32'h80000000, 32'h80000000, 32'h80000000,
                 32'hFFFFFFFF, 32'd1, 32'd32768, 4'd15);
        in_gap_pct = 24;
        out_stall_pct = 24;
        run_random(10);
        item_if.valid <= 1'b0;

        set_grid(32'd0, 32'd0, 32'd0, 32'd131072, 32'd131072, 32'd131072, 4'd0);
        in_gap_pct = 0;
        out_stall_pct = 55;
        hold_req = hold_req + 1;
        run_random(30);
        item_if.valid <= 1'b0;

        set_grid(small_origin(), small_origin(), small_origin(),
                 32'd32768, 32'd32768, 32'd32768, 4'd3);
        in_gap_pct = 24;
        out_stall_pct = 24;
        run_random(15);
        item_if.valid <= 1'b0;
        // sender holds back until the block has gone quiet
        while (due_results.size() != 0) @(posedge clk);
        run_random(15);
        item_if.valid <= 1'b0;

        wait_drained();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
